// File: design/gps_pkg.sv
package gps_pkg;

  localparam int unsigned MaxPeaksDef      = 64;
  localparam int unsigned DriftBitsDef     = 16;
  localparam int unsigned RetentionBitsDef = 24;
  localparam int unsigned SignalBitsDef    = 32;

  localparam int unsigned ARRIVAL_BITS = 6;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned DTOL_BITS = 16;
  localparam int unsigned RBASE_BITS = 24;
  localparam int unsigned RFRAC_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DRIFT_TOL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RT_BASE   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RT_FRAC   = 2'd2;

  localparam logic [DTOL_BITS-1:0]  DTOL_RESET  = 16'd1638;
  localparam logic [RBASE_BITS-1:0] RBASE_RESET = 24'd768;
  localparam logic [RFRAC_BITS-1:0] RFRAC_RESET = 16'd6554;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RK_I,
    S_RK_KEY,
    S_RK_CMP,
    S_SP_I,
    S_SP_ORD,
    S_SP_TOL,
    S_SP_SUM,
    S_SP_JO,
    S_SP_JC,
    S_EM_I,
    S_EM_ORD,
    S_EM_OUT
  } state_e;

endpackage

// File: design/gps_ram.sv
module gps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/greedy_peak_suppression.sv
// Greedy peak suppression.
// Peaks enter on the command channel: one transaction is taken at each rising
// edge with start_i high and busy_o low, and is written to the peak memory.
// A peak that arrives while MAX_PEAKS peaks are held is dropped and the list
// is flagged as overflowed. The peak with last_peak_i set closes the list.
// After the last peak, the block ranks the held peaks by signal (one peak
// memory read per cycle), then runs the suppression pass: each live peak
// that still has peaks behind it in sorted order marks every later live peak
// within both tolerances as suppressed, the pace bounded by the single read
// port of each memory. It then walks the sorted list once more, emitting the
// survivors strongest first.
// busy_o is high from the last peak until that walk has ended.
// Each result is shown for one cycle with result_valid_o; the receiver cannot
// stall, so no result is held back. end_of_list_o marks the final survivor.
// Configuration writes are always ready and belong to idle periods.
// Reset clears the peak count, the overflow flag and the tolerance registers
// to their defaults; the memories are not cleared.
module greedy_peak_suppression
  import gps_pkg::*;
#(
  parameter int unsigned MAX_PEAKS      = MaxPeaksDef,
  parameter int unsigned DRIFT_BITS     = DriftBitsDef,
  parameter int unsigned RETENTION_BITS = RetentionBitsDef,
  parameter int unsigned SIGNAL_BITS    = SignalBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [DRIFT_BITS-1:0]            drift_time_i,
  input  logic [RETENTION_BITS-1:0]        retention_time_i,
  input  logic signed [SIGNAL_BITS-1:0]    peak_signal_i,
  input  logic                             last_peak_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]          cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data_i,
  output logic                             result_valid_o,
  output logic [DRIFT_BITS-1:0]            kept_drift_time_o,
  output logic [RETENTION_BITS-1:0]        kept_retention_time_o,
  output logic signed [SIGNAL_BITS-1:0]    kept_signal_o,
  output logic [ARRIVAL_BITS-1:0]          arrival_index_o,
  output logic                             end_of_list_o,
  output logic                             overflowed_o
);

  localparam int unsigned IDXW = $clog2(MAX_PEAKS);
  localparam int unsigned CNTW = $clog2(MAX_PEAKS + 1);
  localparam int unsigned PKW  = DRIFT_BITS + RETENTION_BITS + SIGNAL_BITS;
  localparam int unsigned ORDW = IDXW + 1;
  localparam int unsigned PRODW = RETENTION_BITS + RFRAC_BITS;
  localparam int unsigned TOLW = ((RETENTION_BITS > RBASE_BITS) ?
                                  RETENTION_BITS : RBASE_BITS) + 1;
  localparam int unsigned DCW  = (DRIFT_BITS > DTOL_BITS) ? DRIFT_BITS : DTOL_BITS;

  state_e state_q, state_d;

  logic [DTOL_BITS-1:0]  dtol_q;
  logic [RBASE_BITS-1:0] rbase_q;
  logic [RFRAC_BITS-1:0] rfrac_q;

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [CNTW-1:0] i_q, i_d, j_q, j_d, rank_q, rank_d, surv_q, surv_d, emit_q, emit_d;
  logic [SIGNAL_BITS-1:0]    key_i_q, key_i_d;
  logic [IDXW-1:0]           s_q, s_d, t_q, t_d;
  logic [DRIFT_BITS-1:0]     dr_s_q, dr_s_d;
  logic [RETENTION_BITS-1:0] rt_s_q, rt_s_d;
  logic [PRODW-1:0]          prod_q, prod_d;
  logic [TOLW-1:0]           tol_q, tol_d;

  // Peak memory port signals.
  logic            pk_we;
  logic [IDXW-1:0] pk_waddr, pk_raddr;
  logic [PKW-1:0]  pk_wdata, pk_rdata;
  // Order memory: sorted position -> {arrival slot, alive}.
  logic            ord_we;
  logic [IDXW-1:0] ord_waddr, ord_raddr;
  logic [ORDW-1:0] ord_wdata, ord_rdata;

  logic [DRIFT_BITS-1:0]     rd_drift;
  logic [RETENTION_BITS-1:0] rd_rt;
  logic [SIGNAL_BITS-1:0]    rd_sig, rd_key;
  logic [IDXW-1:0]           rd_slot;
  logic                      rd_alive;
  logic [CNTW-1:0]           last_idx, rank_next;
  logic                      rank_hit, accept;
  logic [DRIFT_BITS-1:0]     ddiff;
  logic [RETENTION_BITS-1:0] rdiff;
  logic                      suppress;

  gps_ram #(.Width(PKW), .Depth(MAX_PEAKS)) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (pk_we),
    .waddr_i (pk_waddr),
    .wdata_i (pk_wdata),
    .raddr_i (pk_raddr),
    .rdata_o (pk_rdata)
  );

  gps_ram #(.Width(ORDW), .Depth(MAX_PEAKS)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  assign rd_sig   = pk_rdata[SIGNAL_BITS-1:0];
  assign rd_rt    = pk_rdata[SIGNAL_BITS +: RETENTION_BITS];
  assign rd_drift = pk_rdata[SIGNAL_BITS+RETENTION_BITS +: DRIFT_BITS];
  // Flipping the sign bit gives an unsigned key with the same order.
  assign rd_key   = {~rd_sig[SIGNAL_BITS-1], rd_sig[SIGNAL_BITS-2:0]};
  assign rd_slot  = ord_rdata[ORDW-1:1];
  assign rd_alive = ord_rdata[0];

  assign last_idx  = cnt_q - CNTW'(1);
  assign rank_hit  = (rd_key > key_i_q) || ((rd_key == key_i_q) && (j_q < i_q));
  assign rank_next = rank_q + CNTW'(rank_hit);

  assign ddiff = (dr_s_q > rd_drift) ? dr_s_q - rd_drift : rd_drift - dr_s_q;
  assign rdiff = (rt_s_q > rd_rt) ? rt_s_q - rd_rt : rd_rt - rt_s_q;
  assign suppress = (DCW'(ddiff) < DCW'(dtol_q)) && (TOLW'(rdiff) < tol_q);

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    i_d     = i_q;
    j_d     = j_q;
    rank_d  = rank_q;
    surv_d  = surv_q;
    emit_d  = emit_q;
    key_i_d = key_i_q;
    s_d     = s_q;
    t_d     = t_q;
    dr_s_d  = dr_s_q;
    rt_s_d  = rt_s_q;
    prod_d  = prod_q;
    tol_d   = tol_q;
    pk_we     = 1'b0;
    pk_waddr  = cnt_q[IDXW-1:0];
    pk_wdata  = {drift_time_i, retention_time_i, peak_signal_i};
    pk_raddr  = i_q[IDXW-1:0];
    ord_we    = 1'b0;
    ord_waddr = j_q[IDXW-1:0];
    ord_wdata = {t_q, 1'b0};
    ord_raddr = i_q[IDXW-1:0];
    result_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cnt_q < CNTW'(MAX_PEAKS)) begin
            pk_we = 1'b1;
            cnt_d = cnt_q + CNTW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_peak_i) begin
            i_d     = '0;
            state_d = S_RK_I;
          end
        end
      end
      S_RK_I: begin
        pk_raddr = i_q[IDXW-1:0];
        state_d  = S_RK_KEY;
      end
      S_RK_KEY: begin
        key_i_d  = rd_key;
        rank_d   = '0;
        j_d      = '0;
        pk_raddr = '0;
        state_d  = S_RK_CMP;
      end
      S_RK_CMP: begin
        // The rank of peak i is the count of peaks ahead of it in stable order.
        if (j_q == last_idx) begin
          ord_we    = 1'b1;
          ord_waddr = rank_next[IDXW-1:0];
          ord_wdata = {i_q[IDXW-1:0], 1'b1};
          if (i_q == last_idx) begin
            i_d     = '0;
            surv_d  = cnt_q;
            state_d = S_SP_I;
          end else begin
            i_d      = i_q + CNTW'(1);
            pk_raddr = i_d[IDXW-1:0];
            state_d  = S_RK_KEY;
          end
        end else begin
          rank_d   = rank_next;
          j_d      = j_q + CNTW'(1);
          pk_raddr = j_d[IDXW-1:0];
        end
      end
      S_SP_I: begin
        ord_raddr = i_q[IDXW-1:0];
        state_d   = S_SP_ORD;
      end
      S_SP_ORD: begin
        if (!rd_alive || (i_q == last_idx)) begin
          if (i_q == last_idx) begin
            i_d     = '0;
            emit_d  = '0;
            state_d = S_EM_I;
          end else begin
            i_d     = i_q + CNTW'(1);
            state_d = S_SP_I;
          end
        end else begin
          s_d      = rd_slot;
          pk_raddr = rd_slot;
          state_d  = S_SP_TOL;
        end
      end
      S_SP_TOL: begin
        dr_s_d  = rd_drift;
        rt_s_d  = rd_rt;
        prod_d  = PRODW'(rd_rt) * PRODW'(rfrac_q);
        state_d = S_SP_SUM;
      end
      S_SP_SUM: begin
        tol_d     = TOLW'(rbase_q) + TOLW'(prod_q[PRODW-1:RFRAC_BITS]);
        j_d       = i_q + CNTW'(1);
        ord_raddr = j_d[IDXW-1:0];
        state_d   = S_SP_JO;
      end
      S_SP_JO, S_SP_JC: begin
        if ((state_q == S_SP_JO) && rd_alive) begin
          t_d      = rd_slot;
          pk_raddr = rd_slot;
          state_d  = S_SP_JC;
        end else begin
          if ((state_q == S_SP_JC) && suppress) begin
            ord_we    = 1'b1;
            ord_waddr = j_q[IDXW-1:0];
            ord_wdata = {t_q, 1'b0};
            surv_d    = surv_q - CNTW'(1);
          end
          if (j_q == last_idx) begin
            i_d     = i_q + CNTW'(1);
            state_d = S_SP_I;
          end else begin
            j_d       = j_q + CNTW'(1);
            ord_raddr = j_d[IDXW-1:0];
            state_d   = S_SP_JO;
          end
        end
      end
      S_EM_I: begin
        ord_raddr = i_q[IDXW-1:0];
        state_d   = S_EM_ORD;
      end
      S_EM_ORD, S_EM_OUT: begin
        if ((state_q == S_EM_ORD) && rd_alive) begin
          s_d      = rd_slot;
          pk_raddr = rd_slot;
          state_d  = S_EM_OUT;
        end else begin
          if (state_q == S_EM_OUT) begin
            result_valid_o = 1'b1;
            emit_d         = emit_q + CNTW'(1);
          end
          if (i_q == last_idx) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + CNTW'(1);
            state_d = S_EM_I;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign kept_drift_time_o     = rd_drift;
  assign kept_retention_time_o = rd_rt;
  assign kept_signal_o         = rd_sig;
  assign arrival_index_o       = ARRIVAL_BITS'(s_q);
  assign end_of_list_o         = (emit_q + CNTW'(1)) == surv_q;
  assign overflowed_o          = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      rank_q  <= '0;
      surv_q  <= '0;
      emit_q  <= '0;
      dtol_q  <= DTOL_RESET;
      rbase_q <= RBASE_RESET;
      rfrac_q <= RFRAC_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      rank_q  <= rank_d;
      surv_q  <= surv_d;
      emit_q  <= emit_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_DRIFT_TOL: dtol_q  <= cfg_data_i[DTOL_BITS-1:0];
          CFG_RT_BASE:   rbase_q <= cfg_data_i[RBASE_BITS-1:0];
          CFG_RT_FRAC:   rfrac_q <= cfg_data_i[RFRAC_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_i_q <= key_i_d;
    s_q     <= s_d;
    t_q     <= t_d;
    dr_s_q  <= dr_s_d;
    rt_s_q  <= rt_s_d;
    prod_q  <= prod_d;
    tol_q   <= tol_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(MAX_PEAKS))
    else $error("peak count exceeds capacity");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (emit_q < surv_q))
    else $error("more results than survivors");

  a_supp_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ord_we && (state_q == S_SP_JC)) |-> !ord_wdata[0])
    else $error("suppression write must clear the alive mark");

  a_work_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> ((cnt_q != '0) && (i_q < cnt_q)))
    else $error("processing without loaded peaks");

  a_last_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && end_of_list_o) |=> (surv_q != '0))
    else $error("survivor count lost after final result");

endmodule
